FILE: design/pitl_pkg.sv
// Package for the point-in-triangle-list block: request and response
// structs, command and status codes, and slot numbers of a stored entry.
// No dependencies.
package pitl_pkg;

   localparam int FIELD_BITS = 16;

   typedef logic [1:0] cmd_type;
   typedef logic [1:0] status_type;

   localparam cmd_type CMD_CLEAR  = 2'd0;
   localparam cmd_type CMD_APPEND = 2'd1;
   localparam cmd_type CMD_QUERY  = 2'd2;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;

   // Slot order of the coordinates packed into one triangle entry.
   localparam int SLOT_AX    = 0;
   localparam int SLOT_AY    = 1;
   localparam int SLOT_BX    = 2;
   localparam int SLOT_BY    = 3;
   localparam int SLOT_CX    = 4;
   localparam int SLOT_CY    = 5;
   localparam int SLOT_MINX  = 6;
   localparam int SLOT_MINY  = 7;
   localparam int SLOT_MAXX  = 8;
   localparam int SLOT_MAXY  = 9;
   localparam int SLOT_COUNT = 10;

   typedef struct packed {
      cmd_type                       cmd;
      logic signed [FIELD_BITS-1:0]  ax;
      logic signed [FIELD_BITS-1:0]  ay;
      logic signed [FIELD_BITS-1:0]  bx;
      logic signed [FIELD_BITS-1:0]  by_coord;
      logic signed [FIELD_BITS-1:0]  cx;
      logic signed [FIELD_BITS-1:0]  cy;
      logic signed [FIELD_BITS-1:0]  px;
      logic signed [FIELD_BITS-1:0]  py;
   } req_type;

   typedef struct packed {
      logic        inside_res;
      status_type  status;
      logic [6:0]  triangle_count;
   } rsp_type;

endpackage

FILE: design/point_in_triangle_list.sv
// Clear, append, unused commands and rejected queries answer in the cycle after they are accepted.
// A query that passes the polygon box walks the list: a triangle whose box misses
// passes the states RD and BOX; one that reaches the barycentric test passes RD (one
// memory read), BOX, then MUL and SUB for each of three cross products on the shared
// two-multiplier unit, then TEST, and the answer waits in DONE for a free output. One request at a time.
// Reset clears the count, the polygon box and the handshake state; the memory is not cleared.
module point_in_triangle_list
   import pitl_pkg::*;
#(
   parameter int MAX_TRIANGLES = 64,
   parameter int COORD_BITS    = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CB = COORD_BITS;
   localparam int CW = $clog2(MAX_TRIANGLES + 1);
   localparam int IW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
   localparam int EW = SLOT_COUNT * CB;
   localparam int DW = CB + 1;
   localparam int PW = 2 * DW;
   localparam int XW = PW + 1;
   localparam int SW = XW + 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD   = 3'd1;
   localparam logic [2:0] ST_BOX  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_SUB  = 3'd4;
   localparam logic [2:0] ST_TEST = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   function automatic logic signed [CB-1:0] to_coord(input logic signed [FIELD_BITS-1:0] v);
      logic signed [23:0] w;
      w = 24'(v);
      return w[CB-1:0];
   endfunction

   function automatic logic signed [CB-1:0] min3(input logic signed [CB-1:0] a,
                                                 input logic signed [CB-1:0] b,
                                                 input logic signed [CB-1:0] c);
      logic signed [CB-1:0] r;
      r = a;
      if (b < r) r = b;
      if (c < r) r = c;
      return r;
   endfunction

   function automatic logic signed [CB-1:0] max3(input logic signed [CB-1:0] a,
                                                 input logic signed [CB-1:0] b,
                                                 input logic signed [CB-1:0] c);
      logic signed [CB-1:0] r;
      r = a;
      if (b > r) r = b;
      if (c > r) r = c;
      return r;
   endfunction

   function automatic logic signed [CB-1:0] slot(input logic [EW-1:0] e, input int k);
      return e[k*CB +: CB];
   endfunction

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [1:0]            step_ff, step_in;
   logic signed [CB-1:0]  pminx_ff, pminx_in, pminy_ff, pminy_in;
   logic signed [CB-1:0]  pmaxx_ff, pmaxx_in, pmaxy_ff, pmaxy_in;
   logic signed [CB-1:0]  qx_ff, qx_in, qy_ff, qy_in;
   logic signed [DW-1:0]  v0x_ff, v0y_ff, v1x_ff, v1y_ff, v2x_ff, v2y_ff;
   logic signed [DW-1:0]  v0x_in, v0y_in, v1x_in, v1y_in, v2x_in, v2y_in;
   logic signed [PW-1:0]  prod0_ff, prod1_ff, prod0_in, prod1_in;
   logic signed [XW-1:0]  cr_ff, cs_ff, ct_ff, cr_in, cs_in, ct_in;
   logic                  inside_ff, inside_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic [EW-1:0]         rd_ff;
   logic [EW-1:0]         mem [MAX_TRIANGLES];

   logic                  accept;
   logic                  out_free;
   logic                  wr_en;
   logic [EW-1:0]         wr_data;
   logic signed [CB-1:0]  ax, ay, bx, by, cx, cy, nminx, nminy, nmaxx, nmaxy;
   logic signed [CB-1:0]  px, py;
   logic signed [DW-1:0]  op0, op1, op2, op3;
   logic signed [XW-1:0]  cross_val;
   logic signed [SW-1:0]  st_sum;
   logic                  hit;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign ax = to_coord(req_data.ax);
   assign ay = to_coord(req_data.ay);
   assign bx = to_coord(req_data.bx);
   assign by = to_coord(req_data.by_coord);
   assign cx = to_coord(req_data.cx);
   assign cy = to_coord(req_data.cy);
   assign px = to_coord(req_data.px);
   assign py = to_coord(req_data.py);
   assign nminx = min3(ax, bx, cx);
   assign nminy = min3(ay, by, cy);
   assign nmaxx = max3(ax, bx, cx);
   assign nmaxy = max3(ay, by, cy);
   assign wr_data = {nmaxy, nmaxx, nminy, nminx, cy, cx, by, bx, ay, ax};
   assign wr_en = accept && (req_data.cmd == CMD_APPEND) && (count_ff < CW'(MAX_TRIANGLES));

   // Operand selection of the shared cross-product unit: R, then S, then T.
   always_comb begin
      case (step_ff)
         2'd0: begin
            op0 = v0x_ff; op1 = v1y_ff; op2 = v0y_ff; op3 = v1x_ff;
         end
         2'd1: begin
            op0 = v2x_ff; op1 = v1y_ff; op2 = v2y_ff; op3 = v1x_ff;
         end
         2'd2: begin
            op0 = v0x_ff; op1 = v2y_ff; op2 = v0y_ff; op3 = v2x_ff;
         end
         default: begin
            op0 = '0; op1 = '0; op2 = '0; op3 = '0;
         end
      endcase
   end

   assign cross_val = XW'(prod0_ff) - XW'(prod1_ff);
   assign st_sum    = SW'(cs_ff) + SW'(ct_ff);
   always_comb begin
      if (cr_ff > 0) begin
         hit = (cs_ff >= 0) && (ct_ff >= 0) && (st_sum < SW'(cr_ff));
      end else if (cr_ff < 0) begin
         hit = (cs_ff <= 0) && (ct_ff <= 0) && (st_sum > SW'(cr_ff));
      end else begin
         hit = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      pminx_in     = pminx_ff;
      pminy_in     = pminy_ff;
      pmaxx_in     = pmaxx_ff;
      pmaxy_in     = pmaxy_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      v0x_in       = v0x_ff;
      v0y_in       = v0y_ff;
      v1x_in       = v1x_ff;
      v1y_in       = v1y_ff;
      v2x_in       = v2x_ff;
      v2y_in       = v2y_ff;
      prod0_in     = prod0_ff;
      prod1_in     = prod1_ff;
      cr_in        = cr_ff;
      cs_in        = cs_ff;
      ct_in        = ct_ff;
      inside_in    = inside_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_data_in.inside_res = 1'b0;
               rsp_data_in.status     = STATUS_OK;
               rsp_valid_in           = 1'b1;
               case (req_data.cmd)
                  CMD_CLEAR: begin
                     count_in = '0;
                     pminx_in = '0;
                     pminy_in = '0;
                     pmaxx_in = '0;
                     pmaxy_in = '0;
                  end
                  CMD_APPEND: begin
                     if (!wr_en) begin
                        rsp_data_in.status = STATUS_FULL;
                     end else begin
                        count_in = count_ff + 1'b1;
                        if (count_ff == '0) begin
                           pminx_in = nminx;
                           pminy_in = nminy;
                           pmaxx_in = nmaxx;
                           pmaxy_in = nmaxy;
                        end else begin
                           if (nminx < pminx_ff) pminx_in = nminx;
                           if (nminy < pminy_ff) pminy_in = nminy;
                           if (nmaxx > pmaxx_ff) pmaxx_in = nmaxx;
                           if (nmaxy > pmaxy_ff) pmaxy_in = nmaxy;
                        end
                     end
                  end
                  CMD_QUERY: begin
                     if (count_ff == '0) begin
                        rsp_data_in.status = STATUS_EMPTY;
                     end else if (px >= pminx_ff && px <= pmaxx_ff &&
                                  py >= pminy_ff && py <= pmaxy_ff) begin
                        // Inside the polygon box: the answer comes from the walk.
                        rsp_valid_in = rsp_valid_ff && !rsp_ready;
                        rsp_data_in  = rsp_data_ff;
                        qx_in        = px;
                        qy_in        = py;
                        idx_in       = '0;
                        inside_in    = 1'b0;
                        state_in     = ST_RD;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_data_in.triangle_count = 7'(count_in);
               if (state_in == ST_RD) begin
                  rsp_data_in = rsp_data_ff;
               end
            end
         end
         ST_RD: begin
            state_in = ST_BOX;
         end
         ST_BOX: begin
            if (qx_ff < slot(rd_ff, SLOT_MINX) || qx_ff > slot(rd_ff, SLOT_MAXX) ||
                qy_ff < slot(rd_ff, SLOT_MINY) || qy_ff > slot(rd_ff, SLOT_MAXY)) begin
               idx_in   = idx_ff + 1'b1;
               state_in = (idx_in == count_ff) ? ST_DONE : ST_RD;
            end else begin
               v0x_in   = DW'(slot(rd_ff, SLOT_CX)) - DW'(slot(rd_ff, SLOT_AX));
               v0y_in   = DW'(slot(rd_ff, SLOT_CY)) - DW'(slot(rd_ff, SLOT_AY));
               v1x_in   = DW'(slot(rd_ff, SLOT_BX)) - DW'(slot(rd_ff, SLOT_AX));
               v1y_in   = DW'(slot(rd_ff, SLOT_BY)) - DW'(slot(rd_ff, SLOT_AY));
               v2x_in   = DW'(qx_ff) - DW'(slot(rd_ff, SLOT_AX));
               v2y_in   = DW'(qy_ff) - DW'(slot(rd_ff, SLOT_AY));
               step_in  = 2'd0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod0_in = PW'(op0) * PW'(op1);
            prod1_in = PW'(op2) * PW'(op3);
            state_in = ST_SUB;
         end
         ST_SUB: begin
            case (step_ff)
               2'd0:    cr_in = cross_val;
               2'd1:    cs_in = cross_val;
               default: ct_in = cross_val;
            endcase
            step_in  = step_ff + 1'b1;
            state_in = (step_ff == 2'd2) ? ST_TEST : ST_MUL;
         end
         ST_TEST: begin
            idx_in = idx_ff + 1'b1;
            if (hit) begin
               inside_in = 1'b1;
               state_in  = ST_DONE;
            end else begin
               state_in = (idx_in == count_ff) ? ST_DONE : ST_RD;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.inside_res     = inside_ff;
               rsp_data_in.status         = STATUS_OK;
               rsp_data_in.triangle_count = 7'(count_ff);
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pminx_ff     <= '0;
         pminy_ff     <= '0;
         pmaxx_ff     <= '0;
         pmaxy_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pminx_ff     <= pminx_in;
         pminy_ff     <= pminy_in;
         pmaxx_ff     <= pmaxx_in;
         pmaxy_ff     <= pmaxy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      step_ff     <= step_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      v0x_ff      <= v0x_in;
      v0y_ff      <= v0y_in;
      v1x_ff      <= v1x_in;
      v1y_ff      <= v1y_in;
      v2x_ff      <= v2x_in;
      v2y_ff      <= v2y_in;
      prod0_ff    <= prod0_in;
      prod1_ff    <= prod1_in;
      cr_ff       <= cr_in;
      cs_ff       <= cs_in;
      ct_ff       <= ct_in;
      inside_ff   <= inside_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Triangle list memory: one write port for append, one registered read for the walk.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IW-1:0]] <= wr_data;
      end
      if (state_ff == ST_RD) begin
         rd_ff <= mem[idx_ff[IW-1:0]];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_TRIANGLES))
      else $error("triangle count beyond capacity");

   a_walk_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD |-> idx_ff < count_ff)
      else $error("walk reads beyond the stored triangles");

   a_full_append: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.cmd == CMD_APPEND && count_ff == CW'(MAX_TRIANGLES)
      |=> rsp_valid_ff && rsp_data_ff.status == STATUS_FULL && $stable(count_ff))
      else $error("append to a full list not dropped");

   a_inside_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.inside_res |-> rsp_data_ff.status == STATUS_OK)
      else $error("hit reported with a failing status");

endmodule
